FILE: rtl/core/dofp_pkg.sv
// ============================================================================
// dofp_pkg
// Shared types and constants for the display order frame picker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dofp_pkg;

  localparam int IDX_W    = 4;
  localparam int POC_W    = 32;
  localparam int CNT_W    = 5;
  localparam int BUF_DEPTH_DEF = 16;

  localparam logic signed [POC_W-1:0] MAX_POC = 32'sh7FFF_FFFF;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [POC_W-1:0] entry_poc;
    logic [CNT_W-1:0]        occupied_count;
    logic signed [POC_W-1:0] last_shown_poc;
  } dofp_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_index;
    logic             found;
  } dofp_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/display_order_frame_picker_unit.sv
// ============================================================================
// display_order_frame_picker_unit
// POC table in a synchronous RAM; a select scans the occupied slots once and
// returns the next slot to display.
// ============================================================================
// Write: stored on acceptance, no result. Select: the scan walks the first
// count slots (count = saturated occupied_count) through the
// one-read-per-cycle RAM port, then the done state loads the result
// register. One item is in work at a time; a new item is taken while a
// result still waits in the output register.
// Reset clears control only; the POC RAM holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module display_order_frame_picker_unit
  import dofp_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire dofp_req_t req_data,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output dofp_rsp_t      rsp_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t state;

  logic signed [POC_W-1:0] poc_mem [BUF_DEPTH];
  logic signed [POC_W-1:0] mem_rdata;

  logic [CW-1:0]           count;
  logic [CW-1:0]           iss_cnt;
  logic signed [POC_W-1:0] last_poc;

  logic                    rd_vld;
  logic [AW-1:0]           rd_pos;

  logic                    hit;
  logic                    qvalid;
  logic [AW-1:0]           qpos;
  logic signed [POC_W-1:0] qbest;
  logic                    avalid;
  logic [AW-1:0]           apos;
  logic signed [POC_W-1:0] abest;

  logic req_fire;
  logic rsp_fire;
  logic wr_en;
  logic rd_en;
  logic is_mark;
  logic q_take;
  logic a_take;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_fire  = rsp_valid && !rsp_stall;

  assign wr_en = req_fire && (req_data.cmd == CMD_WRITE) &&
                 (int'(req_data.entry_index) < BUF_DEPTH);
  assign rd_en = (state == ST_SCAN) && (iss_cnt < count);

  // A zero POC past slot zero marks a new IDR and closes the qualified range
  assign is_mark = (rd_pos != '0) && (mem_rdata == '0);
  assign q_take  = rd_vld && !hit && !is_mark &&
                   (mem_rdata > last_poc) && (mem_rdata < qbest);
  assign a_take  = rd_vld && (mem_rdata < abest);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      poc_mem[AW'(req_data.entry_index)] <= req_data.entry_poc;
    end
    if (rd_en) begin
      mem_rdata <= poc_mem[iss_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
      qvalid    <= 1'b0;
      avalid    <= 1'b0;
      iss_cnt   <= '0;
    end else begin
      // the done state reloads the output register itself
      if (rsp_fire && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      rd_vld <= rd_en;
      rd_pos <= iss_cnt[AW-1:0];

      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req_data.cmd == CMD_SELECT)) begin
            if (int'(req_data.occupied_count) > BUF_DEPTH) begin
              count <= CW'(BUF_DEPTH);
            end else begin
              count <= CW'(req_data.occupied_count);
            end
            last_poc <= req_data.last_shown_poc;
            iss_cnt  <= '0;
            hit      <= 1'b0;
            qvalid   <= 1'b0;
            avalid   <= 1'b0;
            qbest    <= MAX_POC;
            abest    <= MAX_POC;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            iss_cnt <= iss_cnt + 1'b1;
          end
          if (rd_vld && is_mark) begin
            hit <= 1'b1;
          end
          if (q_take) begin
            qvalid <= 1'b1;
            qpos   <= rd_pos;
            qbest  <= mem_rdata;
          end
          if (a_take) begin
            avalid <= 1'b1;
            apos   <= rd_pos;
            abest  <= mem_rdata;
          end
          // leave once every read is issued and the last one consumed
          if (!rd_en && !rd_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            rsp_data.found <= qvalid || avalid;
            if (qvalid) begin
              rsp_data.best_index <= IDX_W'(qpos);
            end else if (avalid) begin
              rsp_data.best_index <= IDX_W'(apos);
            end else begin
              rsp_data.best_index <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("table written during a scan");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.found) |-> rsp_data.best_index == '0)
    else $error("index not cleared on empty result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> int'(iss_cnt) < BUF_DEPTH)
    else $error("scan beyond table depth");
`endif

endmodule

`default_nettype wire
